FILE: sv/multi_reader_ring_credit_manager_macros.svh
// assertion macros for the ring credit manager
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef MULTI_READER_RING_CREDIT_MANAGER_MACROS_SVH
`define MULTI_READER_RING_CREDIT_MANAGER_MACROS_SVH

// same-cycle implication, off while reset is held
`define MRRCM_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("mrrcm assertion failed");

// next-cycle implication, off while reset is held
`define MRRCM_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("mrrcm assertion failed");

`endif

FILE: sv/mrrcm_pkg.sv
// shared types and constants of the ring credit manager
// no dependencies; imported by mrrcm_rem, the top level and the bench
`default_nettype none

package mrrcm_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int MAX_CONSUMERS = 8;

    localparam int OP_W   = 4;
    localparam int SLOT_W = $clog2(MAX_CONSUMERS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PTR_W  = $clog2(MAX_BLOCKS);
    localparam int DIVD_W = CNT_W + 1;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PROD_CLAIM   = 4'd0,
        OP_PROD_COMMIT  = 4'd1,
        OP_CONS_CLAIM   = 4'd2,
        OP_CONS_RELEASE = 4'd3,
        OP_REGISTER     = 4'd4,
        OP_UNREGISTER   = 4'd5,
        OP_UNLOCK       = 4'd6,
        OP_RESET        = 4'd7,
        OP_QUERY        = 4'd8
    } t_op;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_WP_MOD,
        S_CRED_SWEEP,
        S_MIN_SCAN,
        S_MIN_CHK,
        S_RP_MOD,
        S_LAG_SWEEP,
        S_CI,
        S_CI_MOD,
        S_DONE
    } t_state;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SLOT_W-1:0] consumer_id;
        logic [CNT_W-1:0]  count;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              done_res;
        logic [PTR_W-1:0]  write_index;
        logic [PTR_W-1:0]  read_index;
        logic [CNT_W-1:0]  free_blocks;
        logic              consumer_registered;
        logic [PTR_W-1:0]  consumer_index;
        logic [CNT_W-1:0]  consumer_available;
        logic              unlocked;
    } t_out_word;

    // remainder unit request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_rem_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PTR_W-1:0]  rem;
    } t_rem_rsp;

endpackage

`default_nettype wire

FILE: sv/multi_reader_ring_credit_manager.sv
// Ring credit manager for one producer and up to eight consumers, one word at a time.
// Per word: execute, then a remainder pass for the consumer index when the selected slot is
// registered; a commit adds a write-index remainder pass and a credit sweep, a release or
// unregister adds a lag scan, plus a remainder pass and a lag sweep when the read index moves.
// The next word is accepted once the result word has loaded; output stalls delay that load.
// Synchronous active-low reset: pointers 0, free credit 256, all slots free.
`default_nettype none

`include "multi_reader_ring_credit_manager_macros.svh"

module multi_reader_ring_credit_manager (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [8:0]            i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire mrrcm_pkg::t_in_word   i_in_word,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output mrrcm_pkg::t_out_word       o_out_word,
    input  wire logic                  i_out_stall
);
    import mrrcm_pkg::*;

    // saturating add clamped to the ring size
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b,
                                                 input logic [CNT_W-1:0] lim);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, lim}) ? lim : sum[CNT_W-1:0];
    endfunction

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [SLOT_W-1:0]  r_id, n_id;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_done, n_done;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_min, n_min;
    logic               r_any, n_any;
    logic [PTR_W-1:0]   r_ci, n_ci;

    logic [CNT_W-1:0]   r_bc_cfg, n_bc_cfg;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_free, n_free;
    logic               r_unlock, n_unlock;
    logic [MAX_CONSUMERS-1:0] r_slot_reg, n_slot_reg;
    logic [CNT_W-1:0]   r_credit [MAX_CONSUMERS];
    logic [CNT_W-1:0]   n_credit [MAX_CONSUMERS];
    logic [CNT_W-1:0]   r_lag [MAX_CONSUMERS];
    logic [CNT_W-1:0]   n_lag [MAX_CONSUMERS];

    t_out_word          r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic [CNT_W-1:0]   w_bc;
    logic [CNT_W-1:0]   w_cnt_n;
    logic [SLOT_W-1:0]  w_sel;
    logic               w_sel_reg;
    logic [CNT_W-1:0]   w_sel_credit;
    logic [CNT_W-1:0]   w_sel_lag;
    logic               w_last;

    t_rem_req           rem_req;
    t_rem_rsp           rem_rsp;

    // shared remainder unit for all modulo-ring arithmetic
    mrrcm_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    // effective ring size, clamped to 1..MAX_BLOCKS
    always_comb begin
        if (r_bc_cfg == '0) begin
            w_bc = CNT_W'(1);
        end else if (r_bc_cfg > CNT_W'(MAX_BLOCKS)) begin
            w_bc = CNT_W'(MAX_BLOCKS);
        end else begin
            w_bc = r_bc_cfg;
        end
    end

    assign w_cnt_n = (i_in_word.count > w_bc) ? w_bc : i_in_word.count;

    // one slot read port: sweep counter during sweeps, else the word's slot
    assign w_sel        = (r_state inside {S_CRED_SWEEP, S_MIN_SCAN, S_LAG_SWEEP}) ? r_idx : r_id;
    assign w_sel_reg    = r_slot_reg[w_sel];
    assign w_sel_credit = r_credit[w_sel];
    assign w_sel_lag    = r_lag[w_sel];
    assign w_last       = (r_idx == SLOT_W'(MAX_CONSUMERS - 1));

    // sequencer: next state and datapath updates
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_n        = r_n;
        n_done     = r_done;
        n_idx      = r_idx;
        n_min      = r_min;
        n_any      = r_any;
        n_ci       = r_ci;
        n_bc_cfg   = i_cfg_we ? i_cfg_data : r_bc_cfg;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_free     = r_free;
        n_unlock   = r_unlock;
        n_slot_reg = r_slot_reg;
        n_credit   = r_credit;
        n_lag      = r_lag;
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        rem_req          = '0;
        rem_req.divisor  = w_bc;

        // result taken downstream
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_in_word.operation);
                    n_id    = i_in_word.consumer_id;
                    n_n     = w_cnt_n;
                    n_done  = 1'b0;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_CI;
                case (r_op)
                    OP_PROD_CLAIM: begin
                        if (r_n != '0 && r_free >= r_n) begin
                            n_free = r_free - r_n;
                            n_done = 1'b1;
                        end
                    end
                    OP_PROD_COMMIT: begin
                        if (r_n != '0) begin
                            n_done           = 1'b1;
                            n_idx            = '0;
                            rem_req.start    = 1'b1;
                            rem_req.dividend = DIVD_W'(r_wp) + DIVD_W'(r_n);
                            n_state          = S_WP_MOD;
                        end
                    end
                    OP_CONS_CLAIM: begin
                        if (r_n != '0 && w_sel_reg && w_sel_credit >= r_n) begin
                            n_credit[r_id] = w_sel_credit - r_n;
                            n_done         = 1'b1;
                        end
                    end
                    OP_CONS_RELEASE: begin
                        if (r_n != '0 && w_sel_reg) begin
                            n_lag[r_id] = sat_add(w_sel_lag, r_n, w_bc);
                            n_done      = 1'b1;
                            n_idx       = '0;
                            n_any       = 1'b0;
                            n_state     = S_MIN_SCAN;
                        end
                    end
                    OP_REGISTER: begin
                        if (!w_sel_reg) begin
                            n_slot_reg[r_id] = 1'b1;
                            n_credit[r_id]   = '0;
                            n_lag[r_id]      = '0;
                            n_done           = 1'b1;
                        end
                    end
                    OP_UNREGISTER: begin
                        if (w_sel_reg) begin
                            n_slot_reg[r_id] = 1'b0;
                            n_credit[r_id]   = '0;
                            n_lag[r_id]      = '0;
                            n_done           = 1'b1;
                            n_idx            = '0;
                            n_any            = 1'b0;
                            n_state          = S_MIN_SCAN;
                        end
                    end
                    OP_UNLOCK: begin
                        n_unlock = 1'b1;
                        n_free   = w_bc;
                        for (int i = 0; i < MAX_CONSUMERS; i++) begin
                            if (r_slot_reg[i]) begin
                                n_credit[i] = w_bc;
                            end
                        end
                        n_done = 1'b1;
                    end
                    OP_RESET: begin
                        n_free   = w_bc;
                        n_wp     = '0;
                        n_rp     = '0;
                        n_unlock = 1'b0;
                        for (int i = 0; i < MAX_CONSUMERS; i++) begin
                            n_credit[i] = '0;
                            n_lag[i]    = '0;
                        end
                        n_done = 1'b1;
                    end
                    OP_QUERY: begin
                        n_done = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            // write pointer wrap
            S_WP_MOD: begin
                if (rem_rsp.done) begin
                    n_wp    = rem_rsp.rem;
                    n_state = S_CRED_SWEEP;
                end
            end

            // commit credit to each registered slot
            S_CRED_SWEEP: begin
                if (w_sel_reg) begin
                    n_credit[r_idx] = sat_add(w_sel_credit, r_n, w_bc);
                end
                n_idx = r_idx + SLOT_W'(1);
                if (w_last) begin
                    n_state = S_CI;
                end
            end

            // smallest lag over registered slots
            S_MIN_SCAN: begin
                if (w_sel_reg && (!r_any || w_sel_lag < r_min)) begin
                    n_min = w_sel_lag;
                    n_any = 1'b1;
                end
                n_idx = r_idx + SLOT_W'(1);
                if (w_last) begin
                    n_state = S_MIN_CHK;
                end
            end

            S_MIN_CHK: begin
                if (r_any && r_min != '0) begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = DIVD_W'(r_rp) + DIVD_W'(r_min);
                    n_state          = S_RP_MOD;
                end else begin
                    n_state = S_CI;
                end
            end

            // read pointer wrap and returned credit
            S_RP_MOD: begin
                if (rem_rsp.done) begin
                    n_rp    = rem_rsp.rem;
                    n_free  = sat_add(r_free, r_min, w_bc);
                    n_state = S_LAG_SWEEP;
                end
            end

            // take the common lag out of every registered slot
            S_LAG_SWEEP: begin
                if (w_sel_reg) begin
                    n_lag[r_idx] = w_sel_lag - r_min;
                end
                n_idx = r_idx + SLOT_W'(1);
                if (w_last) begin
                    n_state = S_CI;
                end
            end

            // consumer index of the selected slot
            S_CI: begin
                if (w_sel_reg) begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = DIVD_W'(r_rp) + DIVD_W'(w_sel_lag);
                    n_state          = S_CI_MOD;
                end else begin
                    n_ci    = '0;
                    n_state = S_DONE;
                end
            end

            S_CI_MOD: begin
                if (rem_rsp.done) begin
                    n_ci    = rem_rsp.rem;
                    n_state = S_DONE;
                end
            end

            // load the result word once the output register is free
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.done_res            = r_done;
                    n_out.write_index         = r_wp;
                    n_out.read_index          = r_rp;
                    n_out.free_blocks         = r_free;
                    n_out.consumer_registered = w_sel_reg;
                    n_out.consumer_index      = r_ci;
                    n_out.consumer_available  = w_sel_reg ? w_sel_credit : '0;
                    n_out.unlocked            = r_unlock;
                    n_out_vld                 = 1'b1;
                    n_state                   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_bc_cfg   <= CNT_W'(MAX_BLOCKS);
            r_wp       <= '0;
            r_rp       <= '0;
            r_free     <= CNT_W'(MAX_BLOCKS);
            r_unlock   <= 1'b0;
            r_slot_reg <= '0;
            for (int i = 0; i < MAX_CONSUMERS; i++) begin
                r_credit[i] <= '0;
                r_lag[i]    <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_bc_cfg   <= n_bc_cfg;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_free     <= n_free;
            r_unlock   <= n_unlock;
            r_slot_reg <= n_slot_reg;
            r_credit   <= n_credit;
            r_lag      <= n_lag;
        end
    end

    // per-word working registers and result word
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_n    <= n_n;
        r_done <= n_done;
        r_idx  <= n_idx;
        r_min  <= n_min;
        r_any  <= n_any;
        r_ci   <= n_ci;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // checks
    `MRRCM_ASSERT_IMPL(a_rem_done_when_waiting, rem_rsp.done, (r_state == S_WP_MOD) || (r_state == S_RP_MOD) || (r_state == S_CI_MOD))
    `MRRCM_ASSERT_IMPL(a_idle_unit_quiet, r_state == S_IDLE, !rem_rsp.busy && !rem_rsp.done)
    `MRRCM_ASSERT_IMPL(a_lag_covers_min, (r_state == S_LAG_SWEEP) && w_sel_reg, w_sel_lag >= r_min)
    `MRRCM_ASSERT_NEXT(a_done_loads_output, (r_state == S_DONE) && (!r_out_vld || !i_out_stall), o_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

FILE: sv/mrrcm_rem.sv
// iterative remainder unit: one restoring step per cycle, DIVD_W steps
// depends on mrrcm_pkg
`default_nettype none

module mrrcm_rem (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mrrcm_pkg::t_rem_req i_req,
    output mrrcm_pkg::t_rem_rsp      o_rsp
);
    import mrrcm_pkg::*;

    logic              r_busy;
    logic              r_fin;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_sh;
    logic [CNT_W-1:0]  r_div;
    logic [PTR_W-1:0]  r_rem;

    logic [CNT_W-1:0]  w_trial;
    logic              w_fit;
    logic [PTR_W-1:0]  w_next;

    // shift in next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_sh[DIVD_W-1]};
    assign w_fit   = (w_trial >= r_div);
    assign w_next  = w_fit ? PTR_W'(w_trial - r_div) : w_trial[PTR_W-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sh  <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[DIVD_W-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_fin;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: bench/tb_multi_reader_ring_credit_manager.sv
// self-checking bench for the ring credit manager: directed words, then random phases
// across several ring sizes; expected results come from an in-bench copy of the ring state
// depends on mrrcm_pkg and multi_reader_ring_credit_manager
`default_nettype none

module tb_multi_reader_ring_credit_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrcm_pkg::*;

    localparam int        CYCLE_LIMIT   = 1_000_000;
    localparam int        DRAIN_CYCLES  = 60;
    localparam int        PHASE_COUNT   = 10;
    localparam int        PHASE_WORDS   = 123;
    localparam int        MAX_REPORTS   = 10;
    localparam logic [3:0] OP_SPARE_LO  = 4'd9;
    localparam logic [3:0] OP_SPARE_HI  = 4'd15;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_data = 9'd0;
    logic       in_valid = 1'b0;
    t_in_word   in_word = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_word  out_word;
    logic       out_stall = 1'b0;

    multi_reader_ring_credit_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    // words waiting to be sent and results waiting to arrive
    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;

    // ring state as the bench sees it
    int  blocks_raw;
    int  wr_ptr;
    int  rd_ptr;
    int  free_cnt;
    bit  unlock_seen;
    bit  slot_on[MAX_CONSUMERS];
    int  slot_avail[MAX_CONSUMERS];
    int  slot_lag[MAX_CONSUMERS];

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_blocks(input int raw);
        if (raw < 1) return 1;
        if (raw > MAX_BLOCKS) return MAX_BLOCKS;
        return raw;
    endfunction

    function automatic int sat_sum(input int a, input int b, input int lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic void reset_ring_state();
        blocks_raw  = MAX_BLOCKS;
        wr_ptr      = 0;
        rd_ptr      = 0;
        free_cnt    = MAX_BLOCKS;
        unlock_seen = 1'b0;
        for (int i = 0; i < MAX_CONSUMERS; i++) begin
            slot_on[i]    = 1'b0;
            slot_avail[i] = 0;
            slot_lag[i]   = 0;
        end
    endfunction

    // smallest lag of the live slots moves the read pointer and frees blocks
    function automatic void retire_common_lag(input int bc);
        int  low;
        bit  any;
        low = 0;
        any = 1'b0;
        for (int i = 0; i < MAX_CONSUMERS; i++) begin
            if (slot_on[i] && (!any || slot_lag[i] < low)) begin
                low = slot_lag[i];
                any = 1'b1;
            end
        end
        if (!any || low == 0) return;
        rd_ptr = (rd_ptr + low) % bc;
        for (int i = 0; i < MAX_CONSUMERS; i++)
            if (slot_on[i]) slot_lag[i] -= low;
        free_cnt = sat_sum(free_cnt, low, bc);
    endfunction

    // apply one word to the ring state and form the result it must produce
    function automatic t_out_word apply_ring_op(input t_in_word w);
        int        bc;
        int        n;
        int        id;
        bit        live;
        bit        ok;
        t_out_word r;
        bc   = clamp_blocks(blocks_raw);
        n    = (int'(w.count) > bc) ? bc : int'(w.count);
        id   = int'(w.consumer_id);
        live = slot_on[id];
        ok   = 1'b0;
        case (w.operation)
            OP_PROD_CLAIM: begin
                if (n > 0 && free_cnt >= n) begin
                    free_cnt -= n;
                    ok = 1'b1;
                end
            end
            OP_PROD_COMMIT: begin
                if (n > 0) begin
                    wr_ptr = (wr_ptr + n) % bc;
                    for (int i = 0; i < MAX_CONSUMERS; i++)
                        if (slot_on[i]) slot_avail[i] = sat_sum(slot_avail[i], n, bc);
                    ok = 1'b1;
                end
            end
            OP_CONS_CLAIM: begin
                if (n > 0 && live && slot_avail[id] >= n) begin
                    slot_avail[id] -= n;
                    ok = 1'b1;
                end
            end
            OP_CONS_RELEASE: begin
                if (n > 0 && live) begin
                    slot_lag[id] = sat_sum(slot_lag[id], n, bc);
                    retire_common_lag(bc);
                    ok = 1'b1;
                end
            end
            OP_REGISTER: begin
                if (!live) begin
                    slot_on[id]    = 1'b1;
                    slot_avail[id] = 0;
                    slot_lag[id]   = 0;
                    ok = 1'b1;
                end
            end
            OP_UNREGISTER: begin
                if (live) begin
                    slot_on[id]    = 1'b0;
                    slot_avail[id] = 0;
                    slot_lag[id]   = 0;
                    retire_common_lag(bc);
                    ok = 1'b1;
                end
            end
            OP_UNLOCK: begin
                unlock_seen = 1'b1;
                free_cnt    = bc;
                for (int i = 0; i < MAX_CONSUMERS; i++)
                    if (slot_on[i]) slot_avail[i] = bc;
                ok = 1'b1;
            end
            OP_RESET: begin
                free_cnt = bc;
                wr_ptr   = 0;
                rd_ptr   = 0;
                for (int i = 0; i < MAX_CONSUMERS; i++) begin
                    slot_avail[i] = 0;
                    slot_lag[i]   = 0;
                end
                unlock_seen = 1'b0;
                ok = 1'b1;
            end
            OP_QUERY: begin
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        live = slot_on[id];
        r.done_res            = ok;
        r.write_index         = 8'(wr_ptr);
        r.read_index          = 8'(rd_ptr);
        r.free_blocks         = 9'(free_cnt);
        r.consumer_registered = live;
        r.consumer_index      = live ? 8'((rd_ptr + slot_lag[id]) % bc) : 8'd0;
        r.consumer_available  = live ? 9'(slot_avail[id]) : 9'd0;
        r.unlocked            = unlock_seen;
        return r;
    endfunction

    function automatic void queue_word(input logic [3:0] op, input int id, input int cnt);
        t_in_word w;
        w.operation   = op;
        w.consumer_id = 3'(id);
        w.count       = 9'(cnt);
        pending_words.push_back(w);
    endfunction

    // mostly small counts on a few busy slots, with zero, clamped and full-ring counts mixed in
    function automatic t_in_word random_word(input int bc);
        t_in_word w;
        int       pick;
        int       top;
        pick = $urandom_range(0, 99);
        if (pick < 16)      w.operation = OP_PROD_CLAIM;
        else if (pick < 32) w.operation = OP_PROD_COMMIT;
        else if (pick < 50) w.operation = OP_CONS_CLAIM;
        else if (pick < 68) w.operation = OP_CONS_RELEASE;
        else if (pick < 76) w.operation = OP_REGISTER;
        else if (pick < 81) w.operation = OP_UNREGISTER;
        else if (pick < 83) w.operation = OP_UNLOCK;
        else if (pick < 85) w.operation = OP_RESET;
        else if (pick < 93) w.operation = OP_QUERY;
        else                w.operation = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        w.consumer_id = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2))
                                                    : 3'($urandom_range(0, 7));
        top  = (bc < 8) ? bc : 8;
        pick = $urandom_range(0, 99);
        if (pick < 4)       w.count = 9'd0;
        else if (pick < 10) w.count = 9'($urandom_range(0, 511));
        else if (pick < 14) w.count = 9'(bc);
        else                w.count = 9'($urandom_range(1, top));
        return w;
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        if (mismatches < MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        mismatches++;
    endfunction

    // driver: config tracking, prediction on accept, next word from the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_ring_state();
            in_valid <= 1'b0;
            in_word  <= '0;
            send_gap <= 0;
        end else begin
            if (cfg_we)
                blocks_raw = int'(cfg_data);
            if (in_valid && !in_stall)
                expected_results.push_back(apply_ring_op(in_word));
            if (!in_valid || !in_stall) begin
                if (send_gap > 0 && !calm) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() > 0) begin
                    in_valid <= 1'b1;
                    in_word  <= pending_words.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result word, stall in random bursts
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result word", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    if (out_word.done_res !== want.done_res)
                        flag_mismatch("done_res", int'(want.done_res),
                                      int'(out_word.done_res));
                    if (out_word.write_index !== want.write_index)
                        flag_mismatch("write_index", int'(want.write_index),
                                      int'(out_word.write_index));
                    if (out_word.read_index !== want.read_index)
                        flag_mismatch("read_index", int'(want.read_index),
                                      int'(out_word.read_index));
                    if (out_word.free_blocks !== want.free_blocks)
                        flag_mismatch("free_blocks", int'(want.free_blocks),
                                      int'(out_word.free_blocks));
                    if (out_word.consumer_registered !== want.consumer_registered)
                        flag_mismatch("consumer_registered", int'(want.consumer_registered),
                                      int'(out_word.consumer_registered));
                    if (out_word.consumer_index !== want.consumer_index)
                        flag_mismatch("consumer_index", int'(want.consumer_index),
                                      int'(out_word.consumer_index));
                    if (out_word.consumer_available !== want.consumer_available)
                        flag_mismatch("consumer_available", int'(want.consumer_available),
                                      int'(out_word.consumer_available));
                    if (out_word.unlocked !== want.unlocked)
                        flag_mismatch("unlocked", int'(want.unlocked),
                                      int'(out_word.unlocked));
                end
            end
            if (stall_left > 0 && !calm) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 7);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // block until every queued word is sent and every result is back
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_blocks_count(input int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= 9'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int phase_blocks[PHASE_COUNT];
        phase_blocks = '{256, 1, 2, 0, 511, 5, 17, 100, 257, 256};
        phase_blocks[7] = $urandom_range(3, 255);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words on the full 256-block ring
        queue_word(OP_QUERY, 0, 0);
        queue_word(OP_REGISTER, 0, 0);
        queue_word(OP_REGISTER, 0, 0);
        queue_word(OP_REGISTER, 7, 0);
        queue_word(OP_PROD_CLAIM, 0, 0);
        queue_word(OP_PROD_CLAIM, 0, 511);
        queue_word(OP_PROD_CLAIM, 0, 1);
        queue_word(OP_PROD_COMMIT, 0, 0);
        queue_word(OP_PROD_COMMIT, 0, 300);
        queue_word(OP_CONS_CLAIM, 3, 5);
        queue_word(OP_CONS_CLAIM, 0, 257);
        queue_word(OP_CONS_CLAIM, 7, 300);
        queue_word(OP_CONS_CLAIM, 7, 1);
        queue_word(OP_CONS_RELEASE, 0, 511);
        queue_word(OP_CONS_RELEASE, 7, 100);
        queue_word(OP_CONS_RELEASE, 0, 0);
        queue_word(OP_UNREGISTER, 0, 0);
        queue_word(OP_UNREGISTER, 0, 0);
        queue_word(OP_PROD_COMMIT, 7, 255);
        queue_word(OP_UNLOCK, 7, 0);
        queue_word(OP_RESET, 7, 0);
        queue_word(OP_SPARE_LO, 0, 0);
        queue_word(OP_SPARE_HI, 7, 511);
        queue_word(OP_UNREGISTER, 7, 0);
        queue_word(OP_QUERY, 7, 0);
        wait_for_drain();

        // random phases, one ring size each, the last one without idling
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_blocks_count(phase_blocks[p]);
            if (p == PHASE_COUNT - 1)
                calm = 1'b1;
            repeat (PHASE_WORDS)
                pending_words.push_back(random_word(clamp_blocks(phase_blocks[p])));
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: multi_reader_ring_credit_manager.f
+incdir+sv
sv/mrrcm_pkg.sv
sv/mrrcm_rem.sv
sv/multi_reader_ring_credit_manager.sv
bench/tb_multi_reader_ring_credit_manager.sv
